### rtl/core/sxfr_pkg.sv
package sxfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAYLOAD_LEN = 6;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

    typedef enum logic [1:0] {
        PH_HUNT_FIRST  = 2'd0,
        PH_HUNT_SECOND = 2'd1,
        PH_COLLECT     = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  object_count;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [7:0]  confidence;
    } t_frame;

    typedef struct packed {
        logic   hit;
        t_frame frame;
    } t_parse;

endpackage

### rtl/core/sxfr_rx_if.sv
interface sxfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/sxfr_res_if.sv
interface sxfr_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  object_count;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [7:0]  confidence;

    modport source (
        output valid, output object_count, output center_x, output center_y,
        output confidence, input ready
    );
    modport sink (
        input valid, input object_count, input center_x, input center_y,
        input confidence, output ready
    );
endinterface

### rtl/core/sxfr_parser.sv
module sxfr_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [sxfr_pkg::BYTE_W-1:0] i_byte,
    input  logic [sxfr_pkg::BYTE_W-1:0] i_sync_first,
    input  logic [sxfr_pkg::BYTE_W-1:0] i_sync_second,
    output sxfr_pkg::t_parse          o_parse
);
    import sxfr_pkg::*;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTE_W-1:0]  r_parity, n_parity;
    logic [BYTE_W-1:0]  r_store [PAYLOAD_LEN];
    logic               w_store_we;
    logic               w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT_FIRST;
            r_count  <= '0;
            r_parity <= '0;
        end else if (i_valid) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_parity <= n_parity;
        end
    end

    // write address is always below six when enabled
    always_ff @(posedge i_clk) begin
        if (i_valid && w_store_we) begin
            r_store[r_count] <= i_byte;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_parity   = r_parity;
        w_store_we = 1'b0;
        w_hit      = 1'b0;
        case (r_phase)
            PH_HUNT_SECOND: begin
                if (i_byte == i_sync_second) begin
                    n_phase  = PH_COLLECT;
                    n_count  = '0;
                    n_parity = '0;
                end else begin
                    // mismatching byte is dropped, not retried as first sync
                    n_phase = PH_HUNT_FIRST;
                end
            end
            PH_COLLECT: begin
                if (r_count < CNT_W'(PAYLOAD_LEN)) begin
                    w_store_we = 1'b1;
                    n_parity   = r_parity ^ i_byte;
                    n_count    = r_count + 1'b1;
                end else begin
                    // check byte
                    n_phase = PH_HUNT_FIRST;
                    n_count = '0;
                    w_hit   = (r_parity == i_byte);
                end
            end
            default: begin
                n_phase = (i_byte == i_sync_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
            end
        endcase
    end

    assign o_parse.hit                = i_valid && w_hit;
    assign o_parse.frame.object_count = r_store[0];
    assign o_parse.frame.center_x     = {r_store[2], r_store[1]};
    assign o_parse.frame.center_y     = {r_store[4], r_store[3]};
    assign o_parse.frame.confidence   = r_store[5];

endmodule

### rtl/core/sxfr_out_stage.sv
module sxfr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sxfr_pkg::t_parse i_parse,
    input  logic             i_ready,
    output logic             o_valid,
    output sxfr_pkg::t_frame o_frame,
    output logic             o_free
);
    import sxfr_pkg::*;

    logic   r_valid;
    t_frame r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_parse.hit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_parse.hit) begin
            r_frame <= i_parse.frame;
        end
    end

    // a new item may pass when the register is empty or being drained
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

### rtl/core/sync_xor_frame_receiver_top.sv
// Two-byte sync frame receiver. Received bytes come in on i_rx; the block hunts for the
// first and second sync bytes (registers 0 and 1, reset 0xAA and 0x55), collects six
// payload bytes and a check byte, and on a matching XOR of the payload presents
// object_count, center_x, center_y (little endian) and confidence on o_res. Frames that
// fail the check are dropped without notice. One byte is taken every cycle unless o_res
// stalls; a result is registered as its check byte leaves the input register. Rate is set
// by the single pass through the frame parser between the input register and the result
// register; a stall on o_res holds the input register and so back-pressures i_rx.
module sync_xor_frame_receiver_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sxfr_rx_if.sink                          i_rx,
    sxfr_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [sxfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sxfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sxfr_pkg::*;

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_adv;
    logic              w_out_free;
    logic              w_out_valid;
    t_parse            w_parse;
    t_frame            w_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv      = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    sxfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_adv),
        .i_byte        (r_in_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_parse       (w_parse)
    );

    sxfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv),
        .i_parse (w_parse),
        .i_ready (o_res.ready),
        .o_valid (w_out_valid),
        .o_frame (w_frame),
        .o_free  (w_out_free)
    );

    assign o_res.valid        = w_out_valid;
    assign o_res.object_count = w_frame.object_count;
    assign o_res.center_x     = w_frame.center_x;
    assign o_res.center_y     = w_frame.center_y;
    assign o_res.confidence   = w_frame.confidence;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_out_valid |-> i_rx.ready)
        else $error("input stalled while result register empty");

    a_hit_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_parse.hit |-> r_in_valid && w_out_free)
        else $error("result raised without an item passing");

    a_result_from_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_parse.hit |=> w_out_valid)
        else $error("checked frame not presented");

endmodule

### tb/sv/sync_xor_frame_receiver_top_test.sv
`timescale 1ns / 100ps

module sync_xor_frame_receiver_top_test;
    import sxfr_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 27;
    localparam int PHASE_BYTES   = 225;
    localparam int N_PHASES      = 7;

    // Tracks the sync hunt and payload XOR, and holds the frames still owed by the block.
    class xor_frame_tracker;
        logic [BYTE_W-1:0] sync_a;
        logic [BYTE_W-1:0] sync_b;
        t_phase            phase;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] store [PAYLOAD_LEN];
        logic [BYTE_W-1:0] parity;
        t_frame            frames_due [$];
        int                errors;

        function new();
            sync_a = SYNC_FIRST_RST;
            sync_b = SYNC_SECOND_RST;
            phase  = PH_HUNT_FIRST;
            count  = '0;
            parity = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_SYNC_FIRST) begin
                sync_a = val;
            end else if (idx == CFG_SYNC_SECOND) begin
                sync_b = val;
            end
        endfunction

        function void note_rx_byte(logic [BYTE_W-1:0] b);
            t_frame f;
            case (phase)
                PH_HUNT_SECOND: begin
                    if (b == sync_b) begin
                        phase  = PH_COLLECT;
                        count  = '0;
                        parity = '0;
                    end else begin
                        // dropped, not re-examined as a first sync
                        phase = PH_HUNT_FIRST;
                    end
                end
                PH_COLLECT: begin
                    if (count < PAYLOAD_LEN) begin
                        store[count] = b;
                        parity       = parity ^ b;
                        count        = count + 1'b1;
                    end else begin
                        phase = PH_HUNT_FIRST;
                        count = '0;
                        if (parity == b) begin
                            f.object_count = store[0];
                            f.center_x     = {store[2], store[1]};
                            f.center_y     = {store[4], store[3]};
                            f.confidence   = store[5];
                            frames_due.push_back(f);
                        end
                    end
                end
                default: begin
                    phase = (b == sync_a) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
                end
            endcase
        endfunction

        function void check_frame(t_frame got);
            t_frame want;
            if (frames_due.size() == 0) begin
                $error("unexpected frame: object_count %0h center_x %0h center_y %0h conf %0h",
                       got.object_count, got.center_x, got.center_y, got.confidence);
                errors++;
            end else begin
                want = frames_due.pop_front();
                if (got.object_count !== want.object_count) begin
                    $error("object_count: expected %0h, got %0h",
                           want.object_count, got.object_count);
                    errors++;
                end
                if (got.center_x !== want.center_x) begin
                    $error("center_x: expected %0h, got %0h", want.center_x, got.center_x);
                    errors++;
                end
                if (got.center_y !== want.center_y) begin
                    $error("center_y: expected %0h, got %0h", want.center_y, got.center_y);
                    errors++;
                end
                if (got.confidence !== want.confidence) begin
                    $error("confidence: expected %0h, got %0h", want.confidence, got.confidence);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  calm;
    int                    bytes_sent;
    int                    cycle_count;
    t_frame                seen;
    xor_frame_tracker      tracker;

    sxfr_rx_if  rx_bus ();
    sxfr_res_if res_bus ();

    sync_xor_frame_receiver_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // transfer monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_bus.valid && rx_bus.ready) begin
                tracker.note_rx_byte(rx_bus.rx_byte);
            end
            if (res_bus.valid && res_bus.ready) begin
                seen.object_count = res_bus.object_count;
                seen.center_x     = res_bus.center_x;
                seen.center_y     = res_bus.center_y;
                seen.confidence   = res_bus.confidence;
                tracker.check_frame(seen);
            end
        end
    end

    always @(negedge i_clk) begin
        res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            return 8'h00;
        end else if (roll == 1) begin
            return 8'hFF;
        end
        return BYTE_W'($urandom_range(255));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            rx_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        do @(posedge i_clk); while (!rx_bus.ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic [BYTE_W-1:0] seq [$]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic settle();
        rx_bus.valid <= 1'b0;
        while (tracker.frames_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_syncs(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SYNC_FIRST;
        cfg_data <= first;
        @(negedge i_clk);
        cfg_idx  <= CFG_SYNC_SECOND;
        cfg_data <= second;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        tracker.write_reg(CFG_SYNC_FIRST, first);
        tracker.write_reg(CFG_SYNC_SECOND, second);
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        logic [BYTE_W-1:0] pay [PAYLOAD_LEN];
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] b;
        int                kind;
        int                n;
        kind = $urandom_range(99);
        if (kind < 75) begin
            chk = '0;
            foreach (pay[i]) begin
                pay[i] = rand_byte();
                chk    = chk ^ pay[i];
            end
            if (kind >= 65) begin
                chk = chk ^ BYTE_W'($urandom_range(255, 1));
            end
            send_byte(tracker.sync_a);
            send_byte(tracker.sync_b);
            foreach (pay[i]) send_byte(pay[i]);
            send_byte(chk);
        end else if (kind < 85) begin
            // wrong second sync, often a repeat of the first
            if ($urandom_range(1) == 1) begin
                b = tracker.sync_a;
            end else begin
                b = rand_byte();
            end
            while (b == tracker.sync_b) b = BYTE_W'($urandom_range(255));
            send_byte(tracker.sync_a);
            send_byte(b);
        end else if (kind < 92) begin
            // frame cut short; whatever follows is taken as its payload
            n = $urandom_range(5);
            send_byte(tracker.sync_a);
            send_byte(tracker.sync_b);
            repeat (n) send_byte(rand_byte());
        end else begin
            n = $urandom_range(6, 1);
            repeat (n) send_byte(rand_byte());
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] first_vals  [N_PHASES - 1];
        logic [BYTE_W-1:0] second_vals [N_PHASES - 1];
        int                target;

        first_vals  = '{8'h00, 8'hFF, 8'h3C, 8'h00, 8'hFF, 8'h00};
        second_vals = '{8'hFF, 8'h00, 8'h3C, 8'h00, 8'hFF, 8'h00};
        tracker        = new();
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        calm           = 1'b0;
        bytes_sent     = 0;
        cycle_count    = 0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = '0;
        res_bus.ready  = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // good frame at full scale, wrong second sync then stray second sync,
        // and a zero payload with a failing check byte
        send_bytes('{8'hAA, 8'h55, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
        send_bytes('{8'hAA, 8'hAA, 8'h55});
        send_bytes('{8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            if (p == N_PHASES - 1) begin
                set_syncs(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
            end else if (p > 0) begin
                set_syncs(first_vals[p - 1], second_vals[p - 1]);
            end
            calm   = (p == 2);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_frame();
        end
        calm = 1'b0;
        settle();

        if (tracker.errors == 0 && tracker.frames_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/sxfr_pkg.sv
rtl/core/sxfr_rx_if.sv
rtl/core/sxfr_res_if.sv
rtl/core/sxfr_parser.sv
rtl/core/sxfr_out_stage.sv
rtl/core/sync_xor_frame_receiver_top.sv
tb/sv/sync_xor_frame_receiver_top_test.sv
